@@ design/drre_pkg.sv @@
// drre_pkg: types and constants shared by the DNS response record extractor.
// Depends on nothing; imported by every module of the block.
package drre_pkg;

   localparam int unsigned QueueDepthDefault = 4;
   localparam int unsigned CsrAddrWidth      = 3;
   localparam int unsigned CsrDataWidth      = 32;
   localparam logic [13:0] OffsetMax         = 14'h3FFF;

   localparam logic [CsrAddrWidth-3:0] RegExpectedId = '0;

   localparam logic [1:0] ReasonNone        = 2'd0;
   localparam logic [1:0] ReasonIdMismatch  = 2'd1;
   localparam logic [1:0] ReasonNotResponse = 2'd2;
   localparam logic [1:0] ReasonServerError = 2'd3;

   localparam logic KindAnswer = 1'b0;
   localparam logic KindReject = 1'b1;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'd0,
      PH_QNAME   = 4'd1,
      PH_QFIXED  = 4'd2,
      PH_ANAME   = 4'd3,
      PH_APTR    = 4'd4,
      PH_AINLINE = 4'd5,
      PH_AFIXED  = 4'd6,
      PH_ADATA   = 4'd7,
      PH_DONE    = 4'd8
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  reject_reason;
      logic [3:0]  response_code;
      logic [13:0] name_offset;
      logic [15:0] record_type;
      logic [15:0] record_class;
      logic [31:0] time_to_live;
      logic [15:0] data_length;
      logic        is_address;
      logic [31:0] address;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ design/drre_parser.sv @@
// drre_parser: front part; walks the message one byte per item and forms results.
// Depends on drre_pkg.
module drre_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  drre_pkg::req_type req_data,
   input  logic [15:0]       expected_id,
   output logic              push_valid,
   output drre_pkg::rsp_type push_data
);
   import drre_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [13:0] offset_ff, offset_in;
   logic [31:0] fs_ff, fs_in;
   logic [15:0] ql_ff, ql_in;
   logic [15:0] al_ff, al_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] class_ff, class_in;
   logic [31:0] ttl_ff, ttl_in;
   logic [15:0] dl_ff, dl_in;
   logic [13:0] name_ff, name_in;
   logic [31:0] addr_ff, addr_in;
   logic        rejected_ff, rejected_in;

   logic [7:0]  b;
   logic [31:0] fs_hdr;
   logic [1:0]  reason;
   logic [15:0] dl_dec, ql_dec, al_dec, fix_len;
   logic        afix_done, adata_done, addr_take;
   logic [31:0] addr_next;

   function automatic phase_type after_q(input logic [15:0] q, input logic [15:0] a);
      if (q != 16'd0) begin
         return PH_QNAME;
      end else if (a != 16'd0) begin
         return PH_ANAME;
      end
      return PH_DONE;
   endfunction

   assign b          = req_data.data_byte;
   assign fs_hdr     = {fs_ff[23:0], b};
   assign dl_dec     = dl_ff - 16'd1;
   assign ql_dec     = ql_ff - 16'd1;
   assign al_dec     = al_ff - 16'd1;
   assign fix_len    = {fs_ff[7:0], b};
   assign afix_done  = (phase_ff == PH_AFIXED) && (dl_ff == 16'd1);
   assign adata_done = (phase_ff == PH_ADATA) && (dl_ff == 16'd1);
   assign addr_take  = (fs_ff[15:0] < 16'd4);
   assign addr_next  = addr_take ? {addr_ff[23:0], b} : addr_ff;

   always_comb begin
      if (fs_hdr[31:16] != expected_id) begin
         reason = ReasonIdMismatch;
      end else if (!fs_hdr[15]) begin
         reason = ReasonNotResponse;
      end else if (fs_hdr[3:0] != 4'd0) begin
         reason = ReasonServerError;
      end else begin
         reason = ReasonNone;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_data.last) begin
            phase_in = PH_HEADER;
         end else if (!rejected_ff) begin
            case (phase_ff)
               PH_HEADER: begin
                  if (offset_ff == 14'd11) phase_in = after_q(ql_ff, al_ff);
               end
               PH_QNAME: begin
                  if (b == 8'd0) phase_in = PH_QFIXED;
               end
               PH_QFIXED: begin
                  if (dl_ff == 16'd1) phase_in = after_q(ql_dec, al_ff);
               end
               PH_ANAME: begin
                  if (b[7:6] == 2'b11) phase_in = PH_APTR;
                  else if (b == 8'd0) phase_in = PH_AFIXED;
                  else phase_in = PH_AINLINE;
               end
               PH_APTR: begin
                  phase_in = PH_AFIXED;
               end
               PH_AINLINE: begin
                  if (b == 8'd0) phase_in = PH_AFIXED;
               end
               PH_AFIXED: begin
                  if (dl_ff == 16'd1) begin
                     if (fix_len != 16'd0) phase_in = PH_ADATA;
                     else phase_in = (al_dec != 16'd0) ? PH_ANAME : PH_DONE;
                  end
               end
               PH_ADATA: begin
                  if (dl_ff == 16'd1) phase_in = (al_dec != 16'd0) ? PH_ANAME : PH_DONE;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // datapath
   always_comb begin
      offset_in   = offset_ff;
      fs_in       = fs_ff;
      ql_in       = ql_ff;
      al_in       = al_ff;
      type_in     = type_ff;
      class_in    = class_ff;
      ttl_in      = ttl_ff;
      dl_in       = dl_ff;
      name_in     = name_ff;
      addr_in     = addr_ff;
      rejected_in = rejected_ff;
      if (accept) begin
         if (req_data.last) begin
            offset_in   = '0;
            fs_in       = '0;
            ql_in       = '0;
            al_in       = '0;
            type_in     = '0;
            class_in    = '0;
            ttl_in      = '0;
            dl_in       = '0;
            name_in     = '0;
            addr_in     = '0;
            rejected_in = 1'b0;
         end else begin
            if (offset_ff < OffsetMax) offset_in = offset_ff + 14'd1;
            if (!rejected_ff) begin
               case (phase_ff)
                  PH_HEADER: begin
                     if (offset_ff < 14'd4) fs_in = fs_hdr;
                     if (offset_ff == 14'd3) begin
                        if (reason != ReasonNone) rejected_in = 1'b1;
                     end else if (offset_ff == 14'd4 || offset_ff == 14'd5) begin
                        ql_in = {ql_ff[7:0], b};
                     end else if (offset_ff == 14'd6 || offset_ff == 14'd7) begin
                        al_in = {al_ff[7:0], b};
                     end else if (offset_ff == 14'd11) begin
                        fs_in = '0;
                     end
                  end
                  PH_QNAME: begin
                     if (b == 8'd0) dl_in = 16'd4;
                  end
                  PH_QFIXED: begin
                     dl_in = dl_dec;
                     if (dl_dec == 16'd0) ql_in = ql_dec;
                  end
                  PH_ANAME: begin
                     name_in = offset_ff;
                     if (b[7:6] == 2'b11) begin
                        fs_in = {26'd0, b[5:0]};
                     end else if (b == 8'd0) begin
                        dl_in = 16'd10; fs_in = '0; type_in = '0; class_in = '0; ttl_in = '0;
                     end
                  end
                  PH_APTR: begin
                     name_in = {fs_ff[5:0], b};
                     dl_in = 16'd10; fs_in = '0; type_in = '0; class_in = '0; ttl_in = '0;
                  end
                  PH_AINLINE: begin
                     if (b == 8'd0) begin
                        dl_in = 16'd10; fs_in = '0; type_in = '0; class_in = '0; ttl_in = '0;
                     end
                  end
                  PH_AFIXED: begin
                     if (dl_ff >= 16'd9) type_in = {type_ff[7:0], b};
                     else if (dl_ff >= 16'd7) class_in = {class_ff[7:0], b};
                     else if (dl_ff >= 16'd3) ttl_in = {ttl_ff[23:0], b};
                     else fs_in = {16'd0, fix_len};
                     dl_in = dl_dec;
                     if (dl_dec == 16'd0) begin
                        dl_in   = fix_len;
                        fs_in   = {fix_len, 16'd0};
                        addr_in = '0;
                        if (fix_len == 16'd0) al_in = al_dec;
                     end
                  end
                  PH_ADATA: begin
                     addr_in = addr_next;
                     if (addr_take) fs_in = fs_ff + 32'd1;
                     dl_in = dl_dec;
                     if (dl_dec == 16'd0) al_in = al_dec;
                  end
                  default: begin
                     fs_in = fs_ff;
                  end
               endcase
            end
         end
      end
   end

   // result
   always_comb begin
      push_valid = 1'b0;
      push_data  = '0;
      if (accept && !rejected_ff) begin
         if (phase_ff == PH_HEADER && offset_ff == 14'd3 && reason != ReasonNone) begin
            push_valid              = 1'b1;
            push_data.kind          = KindReject;
            push_data.reject_reason = reason;
            push_data.response_code = fs_hdr[3:0];
         end else if ((afix_done && fix_len == 16'd0) || adata_done) begin
            push_valid             = 1'b1;
            push_data.kind         = KindAnswer;
            push_data.name_offset  = name_ff;
            push_data.record_type  = type_ff;
            push_data.record_class = class_ff;
            push_data.time_to_live = ttl_ff;
            push_data.data_length  = adata_done ? fs_ff[31:16] : 16'd0;
            push_data.is_address   = (type_ff == 16'd1);
            push_data.address      = (adata_done && type_ff == 16'd1) ? addr_next : 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         offset_ff   <= '0;
         fs_ff       <= '0;
         ql_ff       <= '0;
         al_ff       <= '0;
         type_ff     <= '0;
         class_ff    <= '0;
         ttl_ff      <= '0;
         dl_ff       <= '0;
         name_ff     <= '0;
         addr_ff     <= '0;
         rejected_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         offset_ff   <= offset_in;
         fs_ff       <= fs_in;
         ql_ff       <= ql_in;
         al_ff       <= al_in;
         type_ff     <= type_in;
         class_ff    <= class_in;
         ttl_ff      <= ttl_in;
         dl_ff       <= dl_in;
         name_ff     <= name_in;
         addr_ff     <= addr_in;
         rejected_ff <= rejected_in;
      end
   end

endmodule

@@ design/drre_queue.sv @@
// drre_queue: short result queue between the parser and the output stage.
// Depends on drre_pkg.
module drre_queue #(
   parameter int unsigned Depth = drre_pkg::QueueDepthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  drre_pkg::rsp_type          push_data,
   input  logic                       pop,
   output logic                       head_valid,
   output drre_pkg::rsp_type          head_data,
   output drre_pkg::queue_status_type status
);
   import drre_pkg::*;

   localparam int unsigned PtrWidth   = $clog2(Depth);
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   rsp_type               mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == CountWidth'(Depth));
   assign status.empty = (count_ff == '0);
   assign head_valid   = !status.empty;
   assign head_data    = mem_ff[rd_ff];
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop) rd_in = (rd_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ design/drre_emit.sv @@
// drre_emit: back part; output register that hands queued results to the sink.
// Depends on drre_pkg.
module drre_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  drre_pkg::rsp_type head_data,
   output logic              pop,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output drre_pkg::rsp_type rsp_data
);
   import drre_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign pop       = head_valid && (!valid_ff || !rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff && rsp_stall;
      if (pop) begin
         data_in  = head_data;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

@@ design/dns_response_record_extractor.sv @@
// dns_response_record_extractor: top level; parser, result queue, output stage, CSR.
// Depends on drre_pkg, drre_parser, drre_queue, drre_emit.
// Throughput: one message byte per cycle while the result queue is not full (req_stall low).
// A result is written into the queue at the edge that accepts the byte completing it,
// then moves through the output register onto rsp; rsp_stall can hold it in the queue.
// req_stall rises only when the result queue is full.
// Reset (synchronous): parser back to header phase, queue and output emptied,
// expected_id cleared to 0.
module dns_response_record_extractor #(
   parameter int unsigned QueueDepth = drre_pkg::QueueDepthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  drre_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output drre_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [drre_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [drre_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [drre_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import drre_pkg::*;

   logic             accept;
   logic             push_valid, pop, head_valid;
   rsp_type          push_data, head_data;
   queue_status_type q_status;
   logic [15:0]      expected_id_ff, expected_id_in;
   logic             csr_sel_reg;

   assign csr_pready  = 1'b1;
   assign csr_sel_reg = (csr_paddr[CsrAddrWidth-1:2] == RegExpectedId);
   assign csr_prdata  = csr_sel_reg ? {16'd0, expected_id_ff} : '0;

   always_comb begin
      expected_id_in = expected_id_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_reg) begin
         expected_id_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= '0;
      end else begin
         expected_id_ff <= expected_id_in;
      end
   end

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   drre_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .expected_id (expected_id_ff),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   drre_queue #(.Depth(QueueDepth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .status     (q_status)
   );

   drre_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KindReject |->
         rsp_data.record_type == 16'd0 && rsp_data.time_to_live == 32'd0 &&
         rsp_data.is_address == 1'b0 && rsp_data.address == 32'd0 &&
         rsp_data.reject_reason != ReasonNone)
      else $error("reject result carries record fields");

   a_answer_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KindAnswer |->
         rsp_data.reject_reason == ReasonNone && rsp_data.response_code == 4'd0 &&
         rsp_data.is_address == (rsp_data.record_type == 16'd1))
      else $error("answer result fields inconsistent");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      head_valid && !rsp_valid |=> rsp_valid)
      else $error("queued result not moved to output");

endmodule

@@ test/drre_checker.sv @@
`timescale 1ns / 1ps
// drre_checker: watches the byte, result and CSR ports of the DNS record extractor,
// predicts every result from the accepted bytes and compares it field by field.
// Depends on drre_pkg.
module drre_checker
   import drre_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  req_type                 req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  rsp_type                 rsp_data,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic                    csr_pready,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output int unsigned             pending,
   output int unsigned             fail_count,
   output int unsigned             answer_count,
   output int unsigned             reject_count
);

   localparam logic [CsrAddrWidth-1:0] IdAddr = {RegExpectedId, 2'b00};

   rsp_type     records_q[$];
   logic [15:0] id_reg;
   phase_type   phase_q;
   logic [13:0] offset_q;
   logic [31:0] shifter;
   logic [15:0] questions_q;
   logic [15:0] answers_q;
   logic [15:0] type_q;
   logic [15:0] class_q;
   logic [31:0] ttl_q;
   logic [15:0] remain_q;
   logic [13:0] name_q;
   logic [31:0] addr_q;
   logic        dropped_q;

   task automatic report(input string what);
      if (fail_count < 30) begin
         $display("%0t drre_checker: mismatch: %s", $time, what);
      end
      fail_count++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report($sformatf("%s is %0h, expected %0h", field, got, want));
      end
   endtask

   task automatic restart_parser();
      phase_q     = PH_HEADER;
      offset_q    = '0;
      shifter     = '0;
      questions_q = '0;
      answers_q   = '0;
      type_q      = '0;
      class_q     = '0;
      ttl_q       = '0;
      remain_q    = '0;
      name_q      = '0;
      addr_q      = '0;
      dropped_q   = 1'b0;
   endtask

   task automatic leave_questions();
      if (questions_q != 0) begin
         phase_q = PH_QNAME;
      end else if (answers_q != 0) begin
         phase_q = PH_ANAME;
      end else begin
         phase_q = PH_DONE;
      end
   endtask

   task automatic begin_fixed();
      phase_q  = PH_AFIXED;
      remain_q = 16'd10;
      shifter  = '0;
      type_q   = '0;
      class_q  = '0;
      ttl_q    = '0;
   endtask

   task automatic push_record();
      rsp_type r;
      r               = '0;
      r.kind          = KindAnswer;
      r.reject_reason = ReasonNone;
      r.name_offset   = name_q;
      r.record_type   = type_q;
      r.record_class  = class_q;
      r.time_to_live  = ttl_q;
      r.data_length   = shifter[31:16];
      r.is_address    = (type_q == 16'd1);
      r.address       = r.is_address ? addr_q : 32'd0;
      records_q.push_back(r);
      answers_q = answers_q - 16'd1;
      phase_q   = (answers_q != 0) ? PH_ANAME : PH_DONE;
   endtask

   task automatic parse_byte(input req_type item);
      logic [7:0]  b;
      logic [3:0]  rcode;
      logic [1:0]  why;
      int unsigned k;
      rsp_type     r;
      b = item.data_byte;
      if (!dropped_q) begin
         case (phase_q)
            PH_HEADER: begin
               if (offset_q < 4) shifter = {shifter[23:0], b};
               if (offset_q == 3) begin
                  rcode = shifter[3:0];
                  why   = ReasonNone;
                  if (shifter[31:16] != id_reg) begin
                     why = ReasonIdMismatch;
                  end else if (!shifter[15]) begin
                     why = ReasonNotResponse;
                  end else if (rcode != 0) begin
                     why = ReasonServerError;
                  end
                  if (why != ReasonNone) begin
                     r               = '0;
                     r.kind          = KindReject;
                     r.reject_reason = why;
                     r.response_code = rcode;
                     records_q.push_back(r);
                     dropped_q = 1'b1;
                  end
               end else if (offset_q == 4 || offset_q == 5) begin
                  questions_q = {questions_q[7:0], b};
               end else if (offset_q == 6 || offset_q == 7) begin
                  answers_q = {answers_q[7:0], b};
               end else if (offset_q == 11) begin
                  shifter = '0;
                  leave_questions();
               end
            end
            PH_QNAME: begin
               if (b == 0) begin
                  phase_q  = PH_QFIXED;
                  remain_q = 16'd4;
               end
            end
            PH_QFIXED: begin
               remain_q = remain_q - 16'd1;
               if (remain_q == 0) begin
                  questions_q = questions_q - 16'd1;
                  leave_questions();
               end
            end
            PH_ANAME: begin
               name_q = offset_q;
               if (b[7:6] == 2'b11) begin
                  shifter = {26'd0, b[5:0]};
                  phase_q = PH_APTR;
               end else if (b == 0) begin
                  begin_fixed();
               end else begin
                  phase_q = PH_AINLINE;
               end
            end
            PH_APTR: begin
               name_q = {shifter[5:0], b};
               begin_fixed();
            end
            PH_AINLINE: begin
               if (b == 0) begin_fixed();
            end
            PH_AFIXED: begin
               k = 10 - remain_q;
               if (k < 2) begin
                  type_q = {type_q[7:0], b};
               end else if (k < 4) begin
                  class_q = {class_q[7:0], b};
               end else if (k < 8) begin
                  ttl_q = {ttl_q[23:0], b};
               end else begin
                  shifter = {16'd0, shifter[7:0], b};
               end
               remain_q = remain_q - 16'd1;
               if (remain_q == 0) begin
                  remain_q = shifter[15:0];
                  shifter  = shifter << 16;
                  addr_q   = '0;
                  if (remain_q == 0) begin
                     push_record();
                  end else begin
                     phase_q = PH_ADATA;
                  end
               end
            end
            PH_ADATA: begin
               if (shifter[15:0] < 4) begin
                  addr_q  = {addr_q[23:0], b};
                  shifter = shifter + 32'd1;
               end
               remain_q = remain_q - 16'd1;
               if (remain_q == 0) push_record();
            end
            default: ;
         endcase
      end
      if (offset_q != OffsetMax) offset_q = offset_q + 14'd1;
      if (item.last) restart_parser();
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         id_reg = '0;
         restart_parser();
         records_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (records_q.size() == 0) begin
               report("result arrived with nothing expected");
            end else begin
               want = records_q.pop_front();
               check_field("kind", rsp_data.kind, want.kind);
               check_field("reject_reason", rsp_data.reject_reason, want.reject_reason);
               check_field("response_code", rsp_data.response_code, want.response_code);
               check_field("name_offset", rsp_data.name_offset, want.name_offset);
               check_field("record_type", rsp_data.record_type, want.record_type);
               check_field("record_class", rsp_data.record_class, want.record_class);
               check_field("time_to_live", rsp_data.time_to_live, want.time_to_live);
               check_field("data_length", rsp_data.data_length, want.data_length);
               check_field("is_address", rsp_data.is_address, want.is_address);
               check_field("address", rsp_data.address, want.address);
               if (want.kind == KindReject) begin
                  reject_count++;
               end else begin
                  answer_count++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == IdAddr) begin
            id_reg = csr_pwdata[15:0];
         end
         if (req_valid && !req_stall) parse_byte(req_data);
      end
      pending <= records_q.size();
   end

endmodule

@@ test/tb_dns_response_record_extractor.sv @@
`timescale 1ns / 1ps
// tb_dns_response_record_extractor: builds DNS response messages, drives them byte by
// byte with random gaps and result stalls, writes the id register, gives the verdict.
// Depends on drre_pkg, drre_checker and dns_response_record_extractor.
module tb_dns_response_record_extractor;
   import drre_pkg::*;

   localparam logic [CsrAddrWidth-1:0] IdAddr    = {RegExpectedId, 2'b00};
   localparam logic [CsrAddrWidth-1:0] SpareAddr = IdAddr + 3'd4;
   localparam int unsigned StallLimit   = 1000;
   localparam int unsigned PhaseBytes   = 270;
   localparam int unsigned SettleCycles = 4;

   typedef enum int {OwnerPointer, OwnerInline, OwnerRoot, OwnerReserved} owner_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   req_type                 req_data    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   int unsigned pending;
   int unsigned fail_count;
   int unsigned answer_count;
   int unsigned reject_count;

   logic [7:0]  msg[$];
   logic [15:0] cur_id       = '0;
   bit          idle_on      = 1'b1;
   bit          well_formed;
   int unsigned gap_odds;
   int unsigned quiet_cycles = 0;
   int unsigned bytes_sent   = 0;
   int unsigned messages     = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   dns_response_record_extractor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   drre_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_pready   (csr_pready),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .pending      (pending),
      .fail_count   (fail_count),
      .answer_count (answer_count),
      .reject_count (reject_count)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("timeout: no handshake for %0d cycles", StallLimit);
            $display("tb_dns_response_record_extractor: FAIL");
            $finish;
         end
      end
   end

   // result-side backpressure: short stall bursts, with occasional stall-free stretches
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on) begin
            if ($urandom_range(0, 9) == 0) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 16)) @(posedge clock);
               rsp_stall <= 1'b0;
            end else if ($urandom_range(0, 49) == 0) begin
               repeat ($urandom_range(20, 100)) @(posedge clock);
            end
         end
      end
   end

   task automatic put16(input logic [15:0] v);
      msg.push_back(v[15:8]);
      msg.push_back(v[7:0]);
   endtask

   task automatic put32(input logic [31:0] v);
      put16(v[31:16]);
      put16(v[15:0]);
   endtask

   task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                             input logic [15:0] qd, input logic [15:0] an);
      put16(id);
      put16(flags);
      put16(qd);
      put16(an);
      put32($urandom);
   endtask

   task automatic put_question();
      repeat ($urandom_range(0, 8)) msg.push_back(8'($urandom_range(1, 255)));
      msg.push_back(8'h00);
      put32($urandom);
   endtask

   task automatic put_owner(input owner_type style);
      logic [13:0] target;
      case (style)
         OwnerPointer: begin
            target = 14'($urandom);
            msg.push_back({2'b11, target[13:8]});
            msg.push_back(target[7:0]);
         end
         OwnerInline: begin
            msg.push_back(8'($urandom_range(1, 191)));
            repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom_range(1, 255)));
            msg.push_back(8'h00);
         end
         OwnerRoot: msg.push_back(8'h00);
         default: begin
            msg.push_back({($urandom_range(0, 1) == 0) ? 2'b01 : 2'b10, 6'($urandom)});
            msg.push_back(8'h00);
         end
      endcase
   endtask

   task automatic put_fixed(input logic [15:0] rtype, input logic [15:0] dlen);
      put16(rtype);
      put16(16'($urandom));
      put32($urandom);
      put16(dlen);
      repeat (dlen) msg.push_back(8'($urandom));
   endtask

   task automatic put_answer();
      logic [15:0] rtype;
      logic [15:0] dlen;
      int unsigned pick;
      pick = $urandom_range(0, 5);
      put_owner(pick > 3 ? OwnerPointer : owner_type'(pick));
      case ($urandom_range(0, 5))
         0, 1, 2: rtype = 16'd1;
         3:       rtype = 16'd28;
         4:       rtype = 16'd5;
         default: rtype = 16'($urandom);
      endcase
      if (rtype == 16'd1 && $urandom_range(0, 3) != 0) begin
         dlen = 16'd4;
      end else if ($urandom_range(0, 9) == 0) begin
         dlen = 16'($urandom_range(20, 60));
      end else begin
         dlen = 16'($urandom_range(0, 8));
      end
      put_fixed(rtype, dlen);
   endtask

   task automatic send_byte(input req_type item);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_message();
      req_type item;
      gap_odds = (!idle_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
      foreach (msg[i]) begin
         item.data_byte = msg[i];
         item.last      = (i == msg.size() - 1);
         send_byte(item);
      end
      bytes_sent += msg.size();
      messages++;
      msg.delete();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrAddrWidth-1:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_id(input logic [15:0] value);
      wait_idle();
      csr_write(IdAddr, {16'($urandom), value});
      cur_id = value;
   endtask

   task automatic build_random_message();
      int unsigned pick;
      int unsigned keep;
      logic [15:0] id;
      logic [15:0] flags;
      logic [1:0]  why;
      pick        = $urandom_range(0, 99);
      well_formed = (pick < 80);
      if (pick < 80) begin
         put_header(cur_id, {1'b1, 11'($urandom), 4'h0},
                    16'($urandom_range(0, 2)), 16'($urandom_range(0, 4)));
         repeat (msg[5]) put_question();
         repeat (msg[7]) put_answer();
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
         end
         if (pick >= 68) begin
            keep = $urandom_range(1, msg.size() - 1);
            while (msg.size() > keep) void'(msg.pop_back());
         end
      end else if (pick < 92) begin
         why   = 2'($urandom_range(1, 3));
         id    = cur_id;
         flags = 16'($urandom);
         case (why)
            ReasonIdMismatch:  id = cur_id ^ 16'($urandom_range(1, 65535));
            ReasonNotResponse: flags[15] = 1'b0;
            default: begin
               flags[15] = 1'b1;
               if (flags[3:0] == 0) flags[3:0] = 4'($urandom_range(1, 15));
            end
         endcase
         put_header(id, flags, 16'($urandom), 16'($urandom));
         repeat ($urandom_range(0, 30)) msg.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 24)) msg.push_back(8'($urandom));
      end
   endtask

   task automatic run_directed();
      // id register at its reset value
      put_header(16'h0000, 16'h8000, 16'd1, 16'd1);
      put_question();
      put_owner(OwnerPointer);
      put_fixed(16'd1, 16'd4);
      send_message();

      set_id(16'hFFFF);
      // top pointer, inline, root and reserved owners; short and empty data; trailing bytes
      put_header(16'hFFFF, 16'hFFF0, 16'd2, 16'd5);
      put_question();
      put_question();
      msg.push_back(8'hFF);
      msg.push_back(8'hFF);
      put_fixed(16'd1, 16'd2);
      put_owner(OwnerInline);
      put_fixed(16'd1, 16'd0);
      put_owner(OwnerRoot);
      put_fixed(16'd5, 16'd6);
      put_owner(OwnerReserved);
      put_fixed(16'd1, 16'd7);
      msg.push_back(8'hC0);
      msg.push_back(8'h00);
      put_fixed(16'd0, 16'd4);
      repeat (3) msg.push_back(8'($urandom));
      send_message();

      // all three reject reasons present: the id check wins
      put_header(16'h0000, 16'h000F, 16'd0, 16'd1);
      send_message();
      put_header(16'hFFFF, 16'h7FF5, 16'd0, 16'd1);
      send_message();
      // bytes after a server error look like a record but are ignored
      put_header(16'hFFFF, 16'h800F, 16'd0, 16'd1);
      put_owner(OwnerPointer);
      put_fixed(16'd1, 16'd4);
      send_message();

      // header cut short, then a one-byte message
      put16(16'hFFFF);
      msg.push_back(8'h80);
      send_message();
      msg.push_back(8'h00);
      send_message();

      // maximal counts, second record cut in its ttl
      put_header(16'hFFFF, 16'h8000, 16'd0, 16'hFFFF);
      put_owner(OwnerPointer);
      put_fixed(16'd1, 16'd4);
      put_owner(OwnerPointer);
      put16(16'd1);
      put16(16'd1);
      put16(16'h1234);
      send_message();
      put_header(16'hFFFF, 16'h8000, 16'hFFFF, 16'd1);
      put_question();
      send_message();

      // a write to an unused address leaves the id alone
      wait_idle();
      csr_write(SpareAddr, 32'h0000_1234);
      put_header(16'hFFFF, 16'h8000, 16'd0, 16'd1);
      put_owner(OwnerInline);
      put_fixed(16'd1, 16'd4);
      send_message();

      // long data, then a record with all-ones fixed fields and no data
      put_header(16'hFFFF, 16'h8000, 16'd0, 16'd2);
      put_owner(OwnerPointer);
      put_fixed(16'd1, 16'd200);
      put_owner(OwnerInline);
      put16(16'hFFFF);
      put16(16'hFFFF);
      put32(32'hFFFF_FFFF);
      put16(16'd0);
      send_message();
   endtask

   initial begin
      int unsigned useful;
      int unsigned n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (int p = 0; p < 4; p++) begin
         set_id((p == 0) ? 16'h0000 : 16'($urandom));
         if (p == 3) idle_on = 1'b0;
         useful = 0;
         while (useful < PhaseBytes) begin
            build_random_message();
            n = msg.size();
            send_message();
            if (well_formed) useful += n;
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("run: %0d messages, %0d bytes; %0d answer records and %0d rejects checked",
               messages, bytes_sent, answer_count, reject_count);
      if (fail_count == 0) begin
         $display("tb_dns_response_record_extractor: PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("tb_dns_response_record_extractor: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/drre_pkg.sv
design/drre_parser.sv
design/drre_queue.sv
design/drre_emit.sv
design/dns_response_record_extractor.sv
test/drre_checker.sv
test/tb_dns_response_record_extractor.sv
